### hdl/dstwr_pkg.sv
// Shared types and constants for the two-way ranging distance pipeline.
package dstwr_pkg;

  localparam int TS_W        = 40;
  localparam int DIST_W      = 32;
  localparam int CALC_W      = 64;
  localparam int HALF_W      = 32;
  localparam int WRAP_BITS_D = 40;

  localparam int SCALE_NUM_W = 16;
  localparam int SCALE_DEN_W = 17;
  localparam logic [SCALE_NUM_W-1:0] SCALE_NUM = 16'd46903;
  localparam logic [SCALE_DEN_W-1:0] SCALE_DEN = 17'd100000;

  // smallest tof whose scaled distance no longer fits in 32 bits
  localparam logic [CALC_W-1:0] SAT_TOF =
    CALC_W'((64'd4294967296 * 64'd100000 + 64'd46902) / 64'd46903);
  localparam int TOF_W  = 34;                  // SAT_TOF < 2^34

  // distance = (tof * SCALE_K) >> SCALE_SHIFT, SCALE_K = ceil(46903 * 2^52 / 100000);
  // error stays below 2^-18, under the 1e-5 gap of the exact quotient, for tof < 2^34
  localparam int SCALE_SHIFT = 52;
  localparam int SCALE_K_W   = 51;
  localparam logic [SCALE_K_W-1:0] SCALE_K =
    SCALE_K_W'(((128'(SCALE_NUM) << SCALE_SHIFT) + 128'(SCALE_DEN) - 128'd1)
               / 128'(SCALE_DEN));

  typedef struct packed {
    logic [TS_W-1:0] poll_tx_time;
    logic [TS_W-1:0] poll_rx_time;
    logic [TS_W-1:0] resp_tx_time;
    logic [TS_W-1:0] resp_rx_time;
    logic [TS_W-1:0] final_tx_time;
    logic [TS_W-1:0] final_rx_time;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_cm;
    logic              valid_res;
  } out_word_t;

endpackage

### hdl/dstwr_div_pipe.sv
// Restoring divider, one quotient bit per pipeline stage, with a tag carried alongside.
module dstwr_div_pipe
  import dstwr_pkg::*;
#(
  parameter int NUM_W = 64,
  parameter int DEN_W = 64,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);

  // num_r shifts left while quotient bits enter at the bottom
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [TAG_W-1:0] tag_r [NUM_W];
  logic             vld_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [NUM_W-1:0] num_p;
    logic [DEN_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [TAG_W-1:0] tag_p;
    logic             vld_p;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign num_p = in_num;
      assign rem_p = '0;
      assign den_p = in_den;
      assign tag_p = in_tag;
      assign vld_p = in_vld;
    end else begin : g_next
      assign num_p = num_r[i-1];
      assign rem_p = rem_r[i-1];
      assign den_p = den_r[i-1];
      assign tag_p = tag_r[i-1];
      assign vld_p = vld_r[i-1];
    end

    assign trial = {rem_p, num_p[NUM_W-1]};
    assign diff  = trial - {1'b0, den_p};
    assign ge    = (trial >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[i] <= {num_p[NUM_W-2:0], ge};
        rem_r[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[i] <= den_p;
        tag_r[i] <= tag_p;
      end
    end
  end

  assign out_vld = vld_r[NUM_W-1];
  assign out_quo = num_r[NUM_W-1];
  assign out_tag = tag_r[NUM_W-1];

endmodule

### hdl/dstwr_prep.sv
// Wrap correction, interval forming, wrapped products and the division operands.
module dstwr_prep
  import dstwr_pkg::*;
#(
  parameter int WRAP_BITS = WRAP_BITS_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  in_word_t          in_word,
  output logic              out_vld,
  output logic [CALC_W-1:0] out_num,
  output logic [CALC_W-1:0] out_den,
  output logic              out_ok
);

  // corrected stamp: 40-bit value plus up to two wrap periods
  localparam int EW = (WRAP_BITS + 2 > TS_W + 1) ? WRAP_BITS + 2 : TS_W + 1;
  localparam logic [EW-1:0] PERIOD = EW'(1) << WRAP_BITS;

  logic [4:0] vld_r;

  // stage 1: wrap correction
  logic [EW-1:0] t1, t2, t3a, t4a, t5a, t6a, t5b, t6b;
  logic          c4, c5, c3, c6;
  logic [EW-1:0] t1_r, t2_r, t3_r, t4_r, t5_r, t6_r;

  always_comb begin
    t1  = EW'(in_word.poll_tx_time);
    t2  = EW'(in_word.poll_rx_time);
    c4  = EW'(in_word.resp_rx_time) < t1;
    t4a = EW'(in_word.resp_rx_time) + (c4 ? PERIOD : '0);
    t5a = EW'(in_word.final_tx_time) + (c4 ? PERIOD : '0);
    c5  = t5a < t4a;
    t5b = t5a + (c5 ? PERIOD : '0);
    c3  = EW'(in_word.resp_tx_time) < t2;
    t3a = EW'(in_word.resp_tx_time) + (c3 ? PERIOD : '0);
    t6a = EW'(in_word.final_rx_time) + (c3 ? PERIOD : '0);
    c6  = t6a < t3a;
    t6b = t6a + (c6 ? PERIOD : '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t1;
      t2_r <= t2;
      t3_r <= t3a;
      t4_r <= t4a;
      t5_r <= t5b;
      t6_r <= t6b;
    end
  end

  // stage 2: intervals, 64-bit wrapping
  logic [CALC_W-1:0] ra_r, rb_r, da_r, db_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r <= CALC_W'(t4_r) - CALC_W'(t1_r);
      rb_r <= CALC_W'(t6_r) - CALC_W'(t3_r);
      da_r <= CALC_W'(t5_r) - CALC_W'(t4_r);
      db_r <= CALC_W'(t3_r) - CALC_W'(t2_r);
    end
  end

  // stage 3: 32x32 partial products; low-low products kept in full, cross products cut to their low 32 bits
  logic [CALC_W-1:0] ll1_r, ll2_r, den3_r;
  logic [HALF_W-1:0] x1a_r, x1b_r, x2a_r, x2b_r;
  logic [CALC_W-1:0] x1a_f, x1b_f, x2a_f, x2b_f;

  assign x1a_f = ra_r[HALF_W-1:0] * rb_r[CALC_W-1:HALF_W];
  assign x1b_f = ra_r[CALC_W-1:HALF_W] * rb_r[HALF_W-1:0];
  assign x2a_f = da_r[HALF_W-1:0] * db_r[CALC_W-1:HALF_W];
  assign x2b_f = da_r[CALC_W-1:HALF_W] * db_r[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ll1_r  <= ra_r[HALF_W-1:0] * rb_r[HALF_W-1:0];
      ll2_r  <= da_r[HALF_W-1:0] * db_r[HALF_W-1:0];
      x1a_r  <= x1a_f[HALF_W-1:0];
      x1b_r  <= x1b_f[HALF_W-1:0];
      x2a_r  <= x2a_f[HALF_W-1:0];
      x2b_r  <= x2b_f[HALF_W-1:0];
      den3_r <= ra_r + rb_r + da_r + db_r;
    end
  end

  // stage 4: assemble products
  logic [CALC_W-1:0] p1_r, p2_r, den4_r;
  logic [HALF_W-1:0] x1_s, x2_s;

  assign x1_s = x1a_r + x1b_r;
  assign x2_s = x2a_r + x2b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= ll1_r + {x1_s, {HALF_W{1'b0}}};
      p2_r   <= ll2_r + {x2_s, {HALF_W{1'b0}}};
      den4_r <= den3_r;
    end
  end

  // stage 5: numerator and validity
  logic [CALC_W-1:0] num_r, den_r;
  logic              ok_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= p1_r - p2_r;
      den_r <= den4_r;
      ok_r  <= !(p1_r < p2_r) && (den4_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  assign out_vld = vld_r[4];
  assign out_num = num_r;
  assign out_den = den_r;
  assign out_ok  = ok_r;

endmodule

### hdl/ds_twr_time_of_flight.sv
// Pipeline stages from an accepted word to its result: 5 prep, 64 divide,
// 3 scale multiply, 1 output register.
// Throughput: one word per cycle while the output is not stalled; the divider retires one quotient bit per stage.
// A stall at the output holds the whole pipeline in place.
// Reset clears all stage valid bits and the output valid; data registers are not reset.
// Top level: time-of-flight to distance pipeline.
module ds_twr_time_of_flight
  import dstwr_pkg::*;
#(
  parameter int WRAP_BITS = WRAP_BITS_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic              pv, pok;
  logic [CALC_W-1:0] pnum, pden;

  dstwr_prep #(.WRAP_BITS(WRAP_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_word (in_data),
    .out_vld (pv),
    .out_num (pnum),
    .out_den (pden),
    .out_ok  (pok)
  );

  logic              dv;
  logic [CALC_W-1:0] tof;
  logic              dok;

  dstwr_div_pipe #(.NUM_W(CALC_W), .DEN_W(CALC_W), .TAG_W(1)) u_tof_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (pv),
    .in_num  (pnum),
    .in_den  (pden),
    .in_tag  (pok),
    .out_vld (dv),
    .out_quo (tof),
    .out_tag (dok)
  );

  // scale: tof * SCALE_K >> SCALE_SHIFT from four partial products, saturation decided here
  localparam int TL_W = TOF_W / 2;
  localparam int TH_W = TOF_W - TL_W;
  localparam int KL_W = 26;
  localparam int KH_W = SCALE_K_W - KL_W;
  localparam int S0_W = TOF_W + KL_W + 1;
  localparam int S1_W = TOF_W + KH_W + 1;
  localparam int P_W  = TOF_W + SCALE_K_W;

  logic                 s1v_r, s2v_r, s3v_r;
  logic [1:0]           s1tag_r, s2tag_r, s3tag_r;
  logic [TL_W+KL_W-1:0] pp00_r;
  logic [TL_W+KH_W-1:0] pp01_r;
  logic [TH_W+KL_W-1:0] pp10_r;
  logic [TH_W+KH_W-1:0] pp11_r;
  logic [S0_W-1:0]      s0_r;
  logic [S1_W-1:0]      s1_r;
  logic [P_W-1:0]       psum;
  logic [DIST_W-1:0]    dist_r;

  assign psum = P_W'(s0_r) + P_W'({s1_r, {KL_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r <= 1'b0;
      s2v_r <= 1'b0;
      s3v_r <= 1'b0;
    end else if (en) begin
      s1v_r <= dv;
      s2v_r <= s1v_r;
      s3v_r <= s2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r  <= tof[TL_W-1:0] * SCALE_K[KL_W-1:0];
      pp01_r  <= tof[TL_W-1:0] * SCALE_K[SCALE_K_W-1:KL_W];
      pp10_r  <= tof[TOF_W-1:TL_W] * SCALE_K[KL_W-1:0];
      pp11_r  <= tof[TOF_W-1:TL_W] * SCALE_K[SCALE_K_W-1:KL_W];
      s1tag_r <= {dok, tof >= SAT_TOF};
      s0_r    <= S0_W'(pp00_r) + S0_W'({pp10_r, {TL_W{1'b0}}});
      s1_r    <= S1_W'(pp01_r) + S1_W'({pp11_r, {TL_W{1'b0}}});
      s2tag_r <= s1tag_r;
      dist_r  <= psum[SCALE_SHIFT +: DIST_W];
      s3tag_r <= s2tag_r;
    end
  end

  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt.valid_res = s3tag_r[1];
    if (!s3tag_r[1]) begin
      out_data_nxt.distance_cm = '0;
    end else if (s3tag_r[0]) begin
      out_data_nxt.distance_cm = '1;
    end else begin
      out_data_nxt.distance_cm = dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.distance_cm == '0)
    else $error("invalid result with nonzero distance");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_hold_scale: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1v_r))
    else $error("scale stage moved during stall");
`endif

endmodule
